// ===== hdl/tilt_orientation_debounce_unit_defines.svh =====
// Assertion macros for the tilt orientation debounce unit.
// Used by tod_back, the module that carries concurrent checks; needs no other file.
`ifndef TILT_ORIENTATION_DEBOUNCE_UNIT_DEFINES_SVH
`define TILT_ORIENTATION_DEBOUNCE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on the rising clock edge, skipped while reset is asserted
`define TOD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check a property on the rising clock edge, also during reset
`define TOD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TOD_ASSERT(lbl, clk, rstn, prop, msg)
`define TOD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/tod_pkg.sv =====
// Shared types and constants of the tilt orientation debounce unit.
// Used by the front, queue, back and top level; depends on nothing.
package tod_pkg;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_POLL_MS     = 2'd1,
    CFG_STABLE_MS   = 2'd2,
    CFG_THRESHOLD   = 2'd3
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned THRESH_W   = 15;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ACCEL_W    = 16;
  localparam int unsigned MAG_W      = ACCEL_W + 1;

  // Register reset values
  localparam logic                  RST_ENABLE    = 1'b0;
  localparam logic [CFG_DATA_W-1:0] RST_POLL_MS   = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RST_STABLE_MS = 16'd300;
  localparam logic [THRESH_W-1:0]   RST_THRESHOLD = 15'd4096;

  // Rotation and quadrant codes
  localparam logic [1:0] ROT_PORTRAIT       = 2'd0;
  localparam logic [1:0] ROT_LANDSCAPE_CW   = 2'd1;
  localparam logic [1:0] ROT_PORTRAIT_180   = 2'd2;
  localparam logic [1:0] ROT_LANDSCAPE_CCW  = 2'd3;

  // Queue between front and back
  localparam int unsigned TOD_FIFO_DEPTH = 2;
  localparam int unsigned TOD_FIFO_PTR_W = (TOD_FIFO_DEPTH > 1) ? $clog2(TOD_FIFO_DEPTH) : 1;
  localparam int unsigned TOD_FIFO_CNT_W = $clog2(TOD_FIFO_DEPTH + 1);
  localparam logic [TOD_FIFO_PTR_W-1:0] TOD_FIFO_LAST_PTR = TOD_FIFO_PTR_W'(TOD_FIFO_DEPTH - 1);
  localparam logic [TOD_FIFO_CNT_W-1:0] TOD_FIFO_FULL_CNT = TOD_FIFO_CNT_W'(TOD_FIFO_DEPTH);

  // Configuration register set
  typedef struct packed {
    logic                  enable;
    logic [CFG_DATA_W-1:0] poll_interval_ms;
    logic [CFG_DATA_W-1:0] settle_ms;
    logic [THRESH_W-1:0]   flat_limit;
  } cfg_t;

  // Classified sample as queued for the back part
  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              sample_ok;
    logic              flat;
    logic [1:0]        quadrant;
  } entry_t;

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== hdl/tilt_orientation_debounce_unit.sv =====
// An accepted transaction is written into the queue and taken from it into the output
// register, where its result is presented; a stalled output register holds it in the queue.
// Throughput: one transaction per cycle unless stalled; a two-entry queue parts the
// classifying front from the debounce back, and the output register parts the back from the sink.
// Reset (rst_ni low, asynchronous): queue empty, no result pending, rotation portrait,
// registers at enable 0, poll 100 ms, stable 300 ms, threshold 4096.
module tilt_orientation_debounce_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [tod_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [tod_pkg::TIME_W-1:0]         now_ms_i,
  input  logic                               sample_ok_i,
  input  logic signed [tod_pkg::ACCEL_W-1:0] accel_x_i,
  input  logic signed [tod_pkg::ACCEL_W-1:0] accel_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         rotation_o,
  output logic                               rotation_changed_o
);

  tod_pkg::cfg_t         cfg_q, cfg_d;
  tod_pkg::entry_t       front_entry;
  tod_pkg::entry_t       head;
  tod_pkg::fifo_status_t status;
  logic                  push;
  logic                  pop;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tod_pkg::cfg_idx_e'(cfg_idx_i))
        tod_pkg::CFG_ENABLE:    cfg_d.enable           = cfg_data_i[0];
        tod_pkg::CFG_POLL_MS:   cfg_d.poll_interval_ms = cfg_data_i;
        tod_pkg::CFG_STABLE_MS: cfg_d.settle_ms        = cfg_data_i;
        tod_pkg::CFG_THRESHOLD: cfg_d.flat_limit       = cfg_data_i[tod_pkg::THRESH_W-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable           <= tod_pkg::RST_ENABLE;
      cfg_q.poll_interval_ms <= tod_pkg::RST_POLL_MS;
      cfg_q.settle_ms        <= tod_pkg::RST_STABLE_MS;
      cfg_q.flat_limit       <= tod_pkg::RST_THRESHOLD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Accept while the queue has room
  assign in_stall_o = status.full;
  assign push       = in_valid_i && !status.full;

  tod_front u_front (
    .now_ms_i     (now_ms_i),
    .sample_ok_i  (sample_ok_i),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .flat_limit_i (cfg_q.flat_limit),
    .entry_o      (front_entry)
  );

  tod_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (front_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  tod_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .head_i             (head),
    .status_i           (status),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .rotation_o         (rotation_o),
    .rotation_changed_o (rotation_changed_o)
  );

endmodule

// ===== hdl/tod_front.sv =====
// Front part: classifies one accepted sample into a quadrant or flat.
// Depends on tod_pkg.
module tod_front (
  input  logic [tod_pkg::TIME_W-1:0]   now_ms_i,
  input  logic                         sample_ok_i,
  input  logic signed [tod_pkg::ACCEL_W-1:0] accel_x_i,
  input  logic signed [tod_pkg::ACCEL_W-1:0] accel_y_i,
  input  logic [tod_pkg::THRESH_W-1:0] flat_limit_i,
  output tod_pkg::entry_t              entry_o
);

  logic [tod_pkg::MAG_W-1:0] ext_x;
  logic [tod_pkg::MAG_W-1:0] ext_y;
  logic [tod_pkg::MAG_W-1:0] mag_x;
  logic [tod_pkg::MAG_W-1:0] mag_y;
  logic [tod_pkg::MAG_W-1:0] thresh;
  logic                      x_pos;
  logic                      y_pos;

  // Take exact magnitudes, one bit wider so that the most negative value fits
  assign ext_x  = {accel_x_i[tod_pkg::ACCEL_W-1], accel_x_i};
  assign ext_y  = {accel_y_i[tod_pkg::ACCEL_W-1], accel_y_i};
  assign mag_x  = accel_x_i[tod_pkg::ACCEL_W-1] ? (tod_pkg::MAG_W'(0) - ext_x) : ext_x;
  assign mag_y  = accel_y_i[tod_pkg::ACCEL_W-1] ? (tod_pkg::MAG_W'(0) - ext_y) : ext_y;
  assign thresh = tod_pkg::MAG_W'(flat_limit_i);

  assign x_pos = !accel_x_i[tod_pkg::ACCEL_W-1] && (accel_x_i != '0);
  assign y_pos = !accel_y_i[tod_pkg::ACCEL_W-1] && (accel_y_i != '0);

  // Classify: Y wins only when strictly larger, a tie goes to X
  always_comb begin
    entry_o.now_ms    = now_ms_i;
    entry_o.sample_ok = sample_ok_i;
    entry_o.flat      = (mag_x < thresh) && (mag_y < thresh);
    if (mag_y > mag_x) begin
      entry_o.quadrant = y_pos ? tod_pkg::ROT_PORTRAIT_180 : tod_pkg::ROT_PORTRAIT;
    end else begin
      entry_o.quadrant = x_pos ? tod_pkg::ROT_LANDSCAPE_CCW : tod_pkg::ROT_LANDSCAPE_CW;
    end
  end

endmodule

// ===== hdl/tod_fifo.sv =====
// Short queue of classified samples between the front and back parts.
// Depends on tod_pkg.
module tod_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tod_pkg::entry_t       entry_i,
  input  logic                  pop_i,
  output tod_pkg::entry_t       head_o,
  output tod_pkg::fifo_status_t status_o
);

  tod_pkg::entry_t                    mem_q [tod_pkg::TOD_FIFO_DEPTH];
  logic [tod_pkg::TOD_FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [tod_pkg::TOD_FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [tod_pkg::TOD_FIFO_CNT_W-1:0] count_q, count_d;
  logic                               do_push;
  logic                               do_pop;

  assign status_o.full  = (count_q == tod_pkg::TOD_FIFO_FULL_CNT);
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tod_pkg::TOD_FIFO_LAST_PTR) ? '0 :
                 wr_ptr_q + tod_pkg::TOD_FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tod_pkg::TOD_FIFO_LAST_PTR) ? '0 :
                 rd_ptr_q + tod_pkg::TOD_FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + tod_pkg::TOD_FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - tod_pkg::TOD_FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== hdl/tod_back.sv =====
// Back part: poll gating, candidate debounce, commit and output register.
// Depends on tod_pkg and the assertion macro header.
`include "tilt_orientation_debounce_unit_defines.svh"

module tod_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tod_pkg::cfg_t                cfg_i,
  input  tod_pkg::entry_t              head_i,
  input  tod_pkg::fifo_status_t        status_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   rotation_o,
  output logic                         rotation_changed_o
);

  logic [1:0]                  committed_q, committed_d;
  logic [1:0]                  cand_q, cand_d;
  logic [tod_pkg::TIME_W-1:0]  cand_start_q, cand_start_d;
  logic [tod_pkg::TIME_W-1:0]  last_poll_q, last_poll_d;
  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  rotation_q, rotation_d;
  logic                        changed_q, changed_d;
  logic [tod_pkg::TIME_W-1:0]  dt_poll;
  logic [tod_pkg::TIME_W-1:0]  dt_stable;
  logic                        poll_due;
  logic                        stable_due;

  // Take the queue head when the output register is free or being drained
  assign pop_o = !status_i.empty && (!out_valid_q || !out_stall_i);

  // Wrapping time differences
  assign dt_poll    = head_i.now_ms - last_poll_q;
  assign dt_stable  = head_i.now_ms - cand_start_q;
  assign poll_due   = cfg_i.enable && (dt_poll >= tod_pkg::TIME_W'(cfg_i.poll_interval_ms));
  assign stable_due = dt_stable >= tod_pkg::TIME_W'(cfg_i.settle_ms);

  // Update debounce state for the popped transaction
  always_comb begin
    committed_d  = committed_q;
    cand_d       = cand_q;
    cand_start_d = cand_start_q;
    last_poll_d  = last_poll_q;
    changed_d    = changed_q;
    rotation_d   = rotation_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (pop_o) begin
      changed_d   = 1'b0;
      out_valid_d = 1'b1;
      if (poll_due) begin
        last_poll_d = head_i.now_ms;
        if (head_i.sample_ok && !head_i.flat) begin
          if (head_i.quadrant != cand_q) begin
            cand_d       = head_i.quadrant;
            cand_start_d = head_i.now_ms;
          end else if ((head_i.quadrant != committed_q) && stable_due) begin
            committed_d = head_i.quadrant;
            changed_d   = 1'b1;
          end
        end
      end
      rotation_d = committed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q  <= tod_pkg::ROT_PORTRAIT;
      cand_q       <= tod_pkg::ROT_PORTRAIT;
      cand_start_q <= '0;
      last_poll_q  <= '0;
      out_valid_q  <= 1'b0;
      rotation_q   <= tod_pkg::ROT_PORTRAIT;
      changed_q    <= 1'b0;
    end else begin
      committed_q  <= committed_d;
      cand_q       <= cand_d;
      cand_start_q <= cand_start_d;
      last_poll_q  <= last_poll_d;
      out_valid_q  <= out_valid_d;
      rotation_q   <= rotation_d;
      changed_q    <= changed_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign rotation_o         = rotation_q;
  assign rotation_changed_o = changed_q;

  // Output register always mirrors the committed rotation
  `TOD_ASSERT(a_rot_matches, clk_i, rst_ni,
              out_valid_q |-> (rotation_q == committed_q),
              "output rotation differs from committed rotation")
  // A reported commit leaves the candidate equal to the committed rotation
  `TOD_ASSERT(a_commit_cand, clk_i, rst_ni,
              (out_valid_q && changed_q) |-> (cand_q == committed_q),
              "commit reported with a differing candidate")
  // Committed rotation moves only on a popped transaction
  `TOD_ASSERT(a_commit_on_pop, clk_i, rst_ni,
              (committed_q != $past(committed_q)) |-> $past(pop_o),
              "committed rotation changed without a transaction")
  // A popped transaction always lands in the output register
  `TOD_ASSERT(a_pop_fills_out, clk_i, rst_ni, pop_o |=> out_valid_q,
              "popped transaction not presented")

endmodule
